>>> rtl/core/mexp_pkg.sv
// Shared types for the modular exponentiation block.
package mexp_pkg;

    localparam int FIELD_WIDTH = 32;

    // Control that drives every cell of a product chain.
    typedef struct packed {
        logic clr;
        logic step;
        logic dbl;
    } mexp_ctrl_t;

endpackage

>>> rtl/core/mexp_cell.sv
// One bit slice of the modular product chain: accumulator bit, adder and subtractor slice.
module mexp_cell (
    input  logic                   aclk,
    input  mexp_pkg::mexp_ctrl_t   ctrl,
    input  logic                   add_bit,
    input  logic                   mod_bit,
    input  logic                   carry_in,
    input  logic                   borrow_in,
    input  logic                   sel,
    output logic                   r,
    output logic                   carry_out,
    output logic                   borrow_out
);
    import mexp_pkg::*;

    logic r_reg;
    logic y;
    logic t;
    logic d;

    // Doubling adds the accumulator to itself; the add phase adds the gated addend.
    assign y          = ctrl.dbl ? r_reg : add_bit;
    assign t          = r_reg ^ y ^ carry_in;
    assign carry_out  = (r_reg & y) | (carry_in & (r_reg ^ y));
    assign d          = t ^ mod_bit ^ borrow_in;
    assign borrow_out = (~t & mod_bit) | (~(t ^ mod_bit) & borrow_in);
    assign r          = r_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.clr) begin
            r_reg <= 1'b0;
        end else if (ctrl.step) begin
            r_reg <= sel ? d : t;
        end
    end

endmodule

>>> rtl/core/mexp_chain.sv
// Bit-serial modular multiplier built from a row of mexp_cell slices.
module mexp_chain #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                       aclk,
    input  mexp_pkg::mexp_ctrl_t       ctrl,
    input  logic                       mult_bit,
    input  logic [OPERAND_WIDTH-1:0]   addend,
    input  logic [OPERAND_WIDTH-1:0]   modulus,
    output logic [OPERAND_WIDTH-1:0]   prod
);
    import mexp_pkg::*;

    logic [OPERAND_WIDTH:0] carry;
    logic [OPERAND_WIDTH:0] borrow;
    logic                   sel;

    assign carry[0]  = 1'b0;
    assign borrow[0] = 1'b0;
    // Take the difference when the sum reaches the modulus.
    assign sel = carry[OPERAND_WIDTH] | ~borrow[OPERAND_WIDTH];

    for (genvar i = 0; i < OPERAND_WIDTH; i++) begin : g_cell
        mexp_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .add_bit    (mult_bit & addend[i]),
            .mod_bit    (modulus[i]),
            .carry_in   (carry[i]),
            .borrow_in  (borrow[i]),
            .sel        (sel),
            .r          (prod[i]),
            .carry_out  (carry[i+1]),
            .borrow_out (borrow[i+1])
        );
    end

endmodule

>>> rtl/core/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: sequencer and stream ports.
// One item is in work at a time, so a new item is taken only when the sequencer is
// idle. A zero modulus goes straight to the output with the error flag and result zero.
// Each modular product is formed bit-serially: per multiplier bit a doubling step and
// an add step through the cell chain ripple, squaring and multiplying in parallel.
// Reset clears the sequencer and output valid; no clearing pass is needed.
module modular_exponentiation_top #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // base_value, exponent_value, modulus_value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // power_result
    output logic         m_tuser    // modulus_error
);
    import mexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_NEXT, ST_OUT} state_t;

    state_t          state_reg;
    logic            red_reg;
    logic            phase_reg;
    logic [CW-1:0]   bcnt_reg;
    logic [CW-1:0]   ecnt_reg;
    logic [W-1:0]    exp_reg;
    logic [W-1:0]    mod_reg;
    logic [W-1:0]    add_reg;
    logic [W-1:0]    ma_reg;
    logic [W-1:0]    ms_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    sq_reg;
    logic            err_reg;
    logic            m_tvalid_reg;
    logic [W-1:0]    res_reg;
    logic            res_err_reg;

    logic            accept;
    mexp_ctrl_t      ctrl;
    logic [W-1:0]    prod_a;
    logic [W-1:0]    prod_s;
    logic [W-1:0]    new_acc;
    logic [W-1:0]    in_base;
    logic [W-1:0]    in_exp;
    logic [W-1:0]    in_mod;

    assign in_base = s_tdata[W-1:0];
    assign in_exp  = s_tdata[FIELD_WIDTH+W-1:FIELD_WIDTH];
    assign in_mod  = s_tdata[2*FIELD_WIDTH+W-1:2*FIELD_WIDTH];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign ctrl.clr  = accept || (state_reg == ST_NEXT);
    assign ctrl.step = (state_reg == ST_RUN);
    assign ctrl.dbl  = ~phase_reg;

    mexp_chain #(.OPERAND_WIDTH(W)) u_chain_acc (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .mult_bit (ma_reg[W-1]),
        .addend   (add_reg),
        .modulus  (mod_reg),
        .prod     (prod_a)
    );

    mexp_chain #(.OPERAND_WIDTH(W)) u_chain_sq (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .mult_bit (ms_reg[W-1]),
        .addend   (add_reg),
        .modulus  (mod_reg),
        .prod     (prod_s)
    );

    // After the base reduction the accumulator starts at one mod modulus.
    always_comb begin
        if (red_reg) begin
            new_acc = (mod_reg == W'(1)) ? '0 : W'(1);
        end else begin
            new_acc = exp_reg[0] ? prod_a : acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            red_reg      <= 1'b0;
            phase_reg    <= 1'b0;
            bcnt_reg     <= '0;
            ecnt_reg     <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        mod_reg   <= in_mod;
                        exp_reg   <= in_exp;
                        ms_reg    <= in_base;
                        add_reg   <= W'(1);
                        bcnt_reg  <= '0;
                        phase_reg <= 1'b0;
                        red_reg   <= 1'b1;
                        if (in_mod == '0) begin
                            err_reg   <= 1'b1;
                            acc_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            err_reg   <= 1'b0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg) begin
                        ma_reg   <= ma_reg << 1;
                        ms_reg   <= ms_reg << 1;
                        bcnt_reg <= bcnt_reg + 1'b1;
                        if (bcnt_reg == CW'(W-1)) begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT: begin
                    acc_reg <= new_acc;
                    if (!red_reg && ecnt_reg == CW'(W-1)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        sq_reg    <= prod_s;
                        ma_reg    <= new_acc;
                        ms_reg    <= prod_s;
                        add_reg   <= prod_s;
                        bcnt_reg  <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= ST_RUN;
                        if (red_reg) begin
                            red_reg  <= 1'b0;
                            ecnt_reg <= '0;
                        end else begin
                            ecnt_reg <= ecnt_reg + 1'b1;
                            exp_reg  <= exp_reg >> 1;
                        end
                    end
                end
                ST_OUT: begin
                    // Hold until the output register is free.
                    if (!m_tvalid_reg || m_tready) begin
                        res_reg      <= acc_reg;
                        res_err_reg  <= err_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = FIELD_WIDTH'(res_reg);
    assign m_tuser  = res_err_reg;

    a_reduced_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && !red_reg) |-> (acc_reg < mod_reg && sq_reg < mod_reg))
        else $error("operands not reduced during exponent step");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error beat carries nonzero result");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside output state");

endmodule

>>> sim/modular_exponentiation_top_tb.sv
// Self-checking testbench for the modular exponentiation block.
module modular_exponentiation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPW = 32;
    localparam int RANDOM_ITEMS = 280;
    localparam int STALL_LIMIT = 40000;
    localparam int TAIL_CYCLES = 2200;

    typedef struct {
        logic [31:0] power;
        logic        err;
    } power_result_t;

    class power_scoreboard;
        power_result_t pending[$];
        int mismatches;

        function logic [31:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
            logic [63:0] p;
            p = x * y;
            return 32'(p % m);
        endfunction

        function void note_item(logic [31:0] b, logic [31:0] e, logic [31:0] m);
            power_result_t r;
            logic [31:0] acc;
            logic [31:0] sq;
            if (m == 0) begin
                r.power = '0;
                r.err = 1'b1;
            end else begin
                acc = 32'(64'd1 % m);
                sq = b % m;
                for (int i = 0; i < OPW; i++) begin
                    if (e[i]) acc = mulmod(acc, sq, m);
                    sq = mulmod(sq, sq, m);
                end
                r.power = acc;
                r.err = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] p, logic err);
            power_result_t r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: power %h err %b", p, err);
                return;
            end
            r = pending.pop_front();
            if (r.power !== p || r.err !== err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("power: expected %h err %b, got %h err %b",
                             r.power, r.err, p, err);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tuser;

    power_scoreboard sb = new();
    int idle_cycles = 0;

    always #4 aclk = ~aclk;

    modular_exponentiation_top #(.OPERAND_WIDTH(OPW)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Note input beats, check result beats, watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver stall pattern: alternating runs of ready and stall.
    initial begin
        int run;
        @(posedge aresetn);
        forever begin
            run = $urandom_range(1, 30);
            repeat (run) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
            run = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
            repeat (run) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
        end
    end

    task automatic send_item(logic [31:0] b, logic [31:0] e, logic [31:0] m);
        @(negedge aclk);
        s_tdata <= {m, e, b};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_modulus();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 16);
            1: return 32'hFFFF_FFFF;
            2: return $urandom | 32'h8000_0000;
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_exponent();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(32'd5, 32'd3, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(32'd7, 32'd0, 32'd13);
        send_item(32'd7, 32'd0, 32'd1);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_item(32'd100, 32'd1, 32'd7);
        send_item(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE);
        send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd0, 32'd0, 32'd5);
        send_item(32'd0, 32'd9, 32'd5);
        send_item(32'd2, 32'd31, 32'hFFFF_FFFB);
        send_item(32'd3, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001);
        // Hold off until the block has drained.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_item($urandom, rand_exponent(), rand_modulus());
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 400)) @(posedge aclk);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
